@@ src/elevator_call_scheduler_defines.svh @@
// Assertion macros shared by the elevator call scheduler RTL.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef ELEVATOR_CALL_SCHEDULER_DEFINES_SVH
`define ELEVATOR_CALL_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define ECS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define ECS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ecs_pkg.sv @@
// Types, constants and helpers for the elevator call scheduler.
// No dependencies; used by the channel interfaces and the top level.
package ecs_pkg;

  // Table and floor geometry
  localparam int MAX_CALLS   = 16;
  localparam int FLOOR_COUNT = 64;
  localparam int IDX_W       = $clog2(MAX_CALLS);
  localparam int CNT_W       = $clog2(MAX_CALLS + 1);
  localparam int FLOOR_W     = 6;
  localparam int PRIO_W      = 3;
  localparam int STEP_W      = 3;
  localparam int ENTRY_W     = FLOOR_W + PRIO_W;
  localparam int MOVE_W      = FLOOR_W + 2;

  // Scoring
  localparam int PRIO_SCALE  = 100;
  localparam int URGENT_PRIO = 3;
  localparam int SCORE_W     = 11;

  // Configuration port
  localparam int PADDR_W   = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_START_FLOOR = 1'b1;

  // Request operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic signed [MOVE_W-1:0] LAST_FLOOR = MOVE_W'(FLOOR_COUNT - 1);

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    DOOR_CLOSED  = 2'd0,
    DOOR_OPENING = 2'd1,
    DOOR_OPEN    = 2'd2,
    DOOR_CLOSING = 2'd3
  } door_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic               operation;
    logic [FLOOR_W-1:0] floor;
    logic [PRIO_W-1:0]  priority_req;
  } ecs_req_t;

  typedef struct packed {
    logic               accepted;
    logic               dropped;
    logic [FLOOR_W-1:0] car_floor;
    logic [1:0]         travel_direction;
    logic [1:0]         door;
    logic               target_valid;
    logic [FLOOR_W-1:0] target_floor;
    logic               served;
    logic               pending;
  } ecs_res_t;

  // Saturate a signed floor value into the building
  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic signed [MOVE_W-1:0] f);
    logic [FLOOR_W-1:0] r;
    if (f < 0) begin
      r = '0;
    end else if (f > LAST_FLOOR) begin
      r = LAST_FLOOR[FLOOR_W-1:0];
    end else begin
      r = f[FLOOR_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/ecs_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on ecs_pkg for the payload structs.
interface ecs_req_if;
  import ecs_pkg::*;
  logic     valid;
  logic     ready;
  ecs_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ecs_res_if;
  import ecs_pkg::*;
  logic     valid;
  logic     ready;
  ecs_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/elevator_call_scheduler.sv @@
// Elevator car controller with a priority-scored call table kept in a RAM.
// Depends on ecs_pkg, ecs_if.sv and elevator_call_scheduler_defines.svh.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+--------------------------------
//  in_chan  | in        | valid/ready      | operation, floor, priority_req
//  out_chan | out       | valid/ready      | one result per request
//  cfg_*    | in        | APB, pready = 1  | step_size @0x0, start_floor @0x4
//
// An add is accepted and then finishes; a tick is accepted, scans the stored calls
// through the registered RAM read port, decides and finishes (it finishes at once
// on an empty table), and compacts the table between decide and finish after a
// served call (one entry moved per cycle over the single RAM write port).
// Reset is synchronous; the table needs no clearing, only the call count resets.
// One request is in flight at a time; a new one is taken while the last result
// waits in the output register, and finishing stalls until that register frees.
`include "elevator_call_scheduler_defines.svh"

module elevator_call_scheduler (
  input  logic                       clk,
  input  logic                       rst_n,
  ecs_req_if.sink                    in_chan,
  ecs_res_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ecs_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [ecs_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [ecs_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                       cfg_pready
);
  import ecs_pkg::*;

  // Control state
  st_t                 state_r, state_nxt;
  logic [CNT_W-1:0]    call_count_r, call_count_nxt;
  logic [FLOOR_W-1:0]  pos_r, pos_nxt;
  dir_t                heading_r, heading_nxt;
  door_t               door_r, door_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [FLOOR_W-1:0]  start_r, start_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Working registers
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      best_valid_r, best_valid_nxt;
  logic [IDX_W-1:0]          best_idx_r, best_idx_nxt;
  logic signed [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [FLOOR_W-1:0]        best_floor_r, best_floor_nxt;
  ecs_res_t                  res_r, res_nxt;
  ecs_res_t                  out_data_r, out_data_nxt;

  // Call table RAM
  logic [ENTRY_W-1:0] call_mem [MAX_CALLS];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] rd_data_r;

  // Scoring of the entry returned by the RAM
  logic [FLOOR_W-1:0]        ent_floor;
  logic [PRIO_W-1:0]         ent_prio;
  logic [FLOOR_W-1:0]        ent_dist;
  logic [SCORE_W-1:0]        ent_base;
  logic signed [SCORE_W-1:0] ent_score;
  logic                      ent_ok;

  logic                      in_fire;
  logic                      cfg_wr;
  logic [REG_IDX_W-1:0]      cfg_idx;
  logic [MOVE_W-1:0]         sum_up;
  logic [MOVE_W-1:0]         sum_down;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;
  assign cfg_pready     = 1'b1;
  assign cfg_wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx        = cfg_paddr[PADDR_W-1 -: REG_IDX_W];

  // Score the entry read last cycle
  always_comb begin
    ent_floor = rd_data_r[ENTRY_W-1 -: FLOOR_W];
    ent_prio  = rd_data_r[PRIO_W-1:0];
    ent_dist  = (ent_floor >= pos_r) ? (ent_floor - pos_r) : (pos_r - ent_floor);
    ent_base  = SCORE_W'(ent_prio) * SCORE_W'(PRIO_SCALE);
    ent_score = $signed(ent_base) - $signed(SCORE_W'(ent_dist));
    ent_ok    = (heading_r == DIR_IDLE) ||
                (heading_r == DIR_UP && ent_floor >= pos_r) ||
                (heading_r == DIR_DOWN && ent_floor <= pos_r) ||
                (ent_prio >= PRIO_W'(URGENT_PRIO));
    sum_up    = {2'b00, pos_r} + MOVE_W'(step_r);
    sum_down  = {2'b00, pos_r} - MOVE_W'(step_r);
  end

  // Read config registers
  always_comb begin
    case (cfg_idx)
      REG_STEP_SIZE:   cfg_prdata = CFG_DW'(step_r);
      REG_START_FLOOR: cfg_prdata = CFG_DW'(start_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Next state, datapath and RAM control
  always_comb begin
    state_nxt      = state_r;
    call_count_nxt = call_count_r;
    pos_nxt        = pos_r;
    heading_nxt    = heading_r;
    door_nxt       = door_r;
    step_nxt       = step_r;
    start_nxt      = start_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;
    idx_nxt        = idx_r;
    best_valid_nxt = best_valid_r;
    best_idx_nxt   = best_idx_r;
    best_score_nxt = best_score_r;
    best_floor_nxt = best_floor_r;
    res_nxt        = res_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = rd_data_r;
    mem_raddr      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          state_nxt = ST_FINISH;
          if (in_chan.data.operation == OP_ADD) begin
            // Append at the tail, or flag the drop when full
            if (call_count_r < CNT_W'(MAX_CALLS)) begin
              mem_we         = 1'b1;
              mem_waddr      = call_count_r[IDX_W-1:0];
              mem_wdata      = {clamp_floor(MOVE_W'(in_chan.data.floor)),
                                in_chan.data.priority_req};
              call_count_nxt = call_count_r + 1'b1;
              res_nxt.accepted = 1'b1;
            end else begin
              res_nxt.dropped = 1'b1;
            end
          end else if (call_count_r != '0) begin
            // Start the scan at the oldest call
            mem_raddr      = '0;
            idx_nxt        = '0;
            best_valid_nxt = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Compare one entry per cycle; strict compare keeps the earliest on ties
        mem_raddr = idx_r + 1'b1;
        if (ent_ok && (!best_valid_r || ent_score > best_score_r)) begin
          best_valid_nxt = 1'b1;
          best_idx_nxt   = idx_r;
          best_score_nxt = ent_score;
          best_floor_nxt = ent_floor;
        end
        if ({1'b0, idx_r} == call_count_r - 1'b1) begin
          state_nxt = ST_DECIDE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_DECIDE: begin
        state_nxt = ST_FINISH;
        if (best_valid_r) begin
          res_nxt.target_valid = 1'b1;
          res_nxt.target_floor = best_floor_r;
          if (pos_r < best_floor_r) begin
            heading_nxt = DIR_UP;
            pos_nxt     = clamp_floor($signed(sum_up));
          end else if (pos_r > best_floor_r) begin
            heading_nxt = DIR_DOWN;
            pos_nxt     = clamp_floor($signed(sum_down));
          end else begin
            // At the target: advance the door cycle
            case (door_r)
              DOOR_CLOSED:  door_nxt = DOOR_OPENING;
              DOOR_OPENING: door_nxt = DOOR_OPEN;
              DOOR_OPEN:    door_nxt = DOOR_CLOSING;
              DOOR_CLOSING: begin
                door_nxt        = DOOR_CLOSED;
                heading_nxt     = DIR_IDLE;
                res_nxt.served  = 1'b1;
                call_count_nxt  = call_count_r - 1'b1;
                // Compact if later entries follow the served one
                if ({1'b0, best_idx_r} < call_count_r - 1'b1) begin
                  mem_raddr = best_idx_r + 1'b1;
                  idx_nxt   = best_idx_r + 1'b1;
                  state_nxt = ST_SHIFT;
                end
              end
              default: door_nxt = DOOR_CLOSED;
            endcase
          end
        end
      end

      ST_SHIFT: begin
        // Move entry idx down by one; the write and the next read never collide
        mem_we    = 1'b1;
        mem_waddr = idx_r - 1'b1;
        mem_wdata = rd_data_r;
        mem_raddr = idx_r + 1'b1;
        if ({1'b0, idx_r} == call_count_r) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_FINISH: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt                  = res_r;
          out_data_nxt.car_floor        = pos_r;
          out_data_nxt.travel_direction = heading_r;
          out_data_nxt.door             = door_r;
          out_data_nxt.pending          = (call_count_r != '0);
          state_nxt                     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Configuration writes must arrive only while idle; the user must keep to this, the block does not enforce it
    if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_SIZE: step_nxt = cfg_pwdata[STEP_W-1:0];
        REG_START_FLOOR: begin
          start_nxt = cfg_pwdata[FLOOR_W-1:0];
          pos_nxt   = clamp_floor(MOVE_W'(cfg_pwdata[FLOOR_W-1:0]));
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      call_count_r <= '0;
      pos_r        <= clamp_floor('0);
      heading_r    <= DIR_IDLE;
      door_r       <= DOOR_CLOSED;
      step_r       <= STEP_W'(1);
      start_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      call_count_r <= call_count_nxt;
      pos_r        <= pos_nxt;
      heading_r    <= heading_nxt;
      door_r       <= door_nxt;
      step_r       <= step_nxt;
      start_r      <= start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    best_valid_r <= best_valid_nxt;
    best_idx_r   <= best_idx_nxt;
    best_score_r <= best_score_nxt;
    best_floor_r <= best_floor_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Call table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      call_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= call_mem[mem_raddr];
  end

  `ECS_ASSERT_IMP(a_count_bound, 1'b1, call_count_r <= CNT_W'(MAX_CALLS),
                  "call count exceeds table size")
  `ECS_ASSERT_NXT(a_full_hold,
                  in_fire && in_chan.data.operation == OP_ADD &&
                  call_count_r == CNT_W'(MAX_CALLS),
                  call_count_r == CNT_W'(MAX_CALLS), "full table changed on dropped add")
  `ECS_ASSERT_IMP(a_served_idle, out_valid_r && out_data_r.served,
                  out_data_r.target_valid && out_data_r.door == DOOR_CLOSED &&
                  out_data_r.travel_direction == DIR_IDLE, "served result with car not idle")
  `ECS_ASSERT_IMP(a_add_flags, out_valid_r, !(out_data_r.accepted && out_data_r.dropped),
                  "request both accepted and dropped")
  `ECS_ASSERT_NXT(a_scan_pos_hold, state_r == ST_SCAN && !cfg_wr, pos_r == $past(pos_r),
                  "car moved during scan")

endmodule

@@ test/elevator_call_scheduler_tb.sv @@
// Self-checking testbench for the elevator call scheduler: directed and random
// requests, APB setting changes, random idling and a long output hold-off.
// Depends on ecs_pkg, the ecs_if channel interfaces and the scheduler RTL.
module elevator_call_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE      = 60;
  localparam int          NO_SCORE    = -100000;

  // Tracks the car and call table, and checks each result in request order
  class car_scoreboard;
    bit [FLOOR_W-1:0] call_floor_q[$];
    bit [PRIO_W-1:0]  call_prio_q[$];
    bit [FLOOR_W-1:0] position;
    bit [STEP_W-1:0]  step;
    dir_t             heading;
    door_t            door_pos;
    ecs_res_t         expected_status_q[$];
    int               failures;

    function new();
      position = '0;
      step = 3'd1;
      heading = DIR_IDLE;
      door_pos = DOOR_CLOSED;
      failures = 0;
    endfunction

    function int outstanding();
      return expected_status_q.size();
    endfunction

    function void apply_setting(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] value);
      if (idx == REG_STEP_SIZE) begin
        step = value[STEP_W-1:0];
      end else if (idx == REG_START_FLOOR) begin
        position = value[FLOOR_W-1:0];
      end
    endfunction

    function bit eligible(int i);
      if (heading == DIR_IDLE) return 1'b1;
      if (heading == DIR_UP && call_floor_q[i] >= position) return 1'b1;
      if (heading == DIR_DOWN && call_floor_q[i] <= position) return 1'b1;
      return call_prio_q[i] >= URGENT_PRIO;
    endfunction

    // Advance the car for one accepted request and queue the status it yields
    function void note_request(ecs_req_t r);
      ecs_res_t e;
      int pick;
      int best;
      int gap;
      int score;
      int next_pos;
      bit [FLOOR_W-1:0] target;
      e = '0;
      if (r.operation == OP_ADD) begin
        if (call_floor_q.size() < MAX_CALLS) begin
          call_floor_q.insert(call_floor_q.size(), r.floor);
          call_prio_q.insert(call_prio_q.size(), r.priority_req);
          e.accepted = 1'b1;
        end else begin
          e.dropped = 1'b1;
        end
      end else if (call_floor_q.size() > 0) begin
        pick = -1;
        best = NO_SCORE;
        for (int i = 0; i < call_floor_q.size(); i++) begin
          if (eligible(i)) begin
            gap = int'(call_floor_q[i]) - int'(position);
            if (gap < 0) gap = -gap;
            score = int'(call_prio_q[i]) * PRIO_SCALE - gap;
            if (score > best) begin
              best = score;
              pick = i;
            end
          end
        end
        if (pick >= 0) begin
          target = call_floor_q[pick];
          e.target_valid = 1'b1;
          e.target_floor = target;
          if (position < target) begin
            heading = DIR_UP;
            next_pos = int'(position) + int'(step);
            position = (next_pos > FLOOR_COUNT - 1) ? FLOOR_W'(FLOOR_COUNT - 1)
                                                     : FLOOR_W'(next_pos);
          end else if (position > target) begin
            heading = DIR_DOWN;
            next_pos = int'(position) - int'(step);
            position = (next_pos < 0) ? '0 : FLOOR_W'(next_pos);
          end else begin
            case (door_pos)
              DOOR_CLOSED:  door_pos = DOOR_OPENING;
              DOOR_OPENING: door_pos = DOOR_OPEN;
              DOOR_OPEN:    door_pos = DOOR_CLOSING;
              default: begin
                door_pos = DOOR_CLOSED;
                heading = DIR_IDLE;
                call_floor_q.delete(pick);
                call_prio_q.delete(pick);
                e.served = 1'b1;
              end
            endcase
          end
        end
      end
      e.car_floor = position;
      e.travel_direction = heading;
      e.door = door_pos;
      e.pending = call_floor_q.size() > 0;
      expected_status_q.insert(expected_status_q.size(), e);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        if (failures <= 50) begin
          $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
        end
      end
    endfunction

    // Check one delivered status against the oldest expectation
    function void check_status(ecs_res_t got);
      ecs_res_t want;
      if (expected_status_q.size() == 0) begin
        failures++;
        $display("%0t unexpected status: expected none, actual %h", $time, got);
        return;
      end
      want = expected_status_q.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("dropped", want.dropped, got.dropped);
      compare("car_floor", want.car_floor, got.car_floor);
      compare("travel_direction", want.travel_direction, got.travel_direction);
      compare("door", want.door, got.door);
      compare("target_valid", want.target_valid, got.target_valid);
      compare("target_floor", want.target_floor, got.target_floor);
      compare("served", want.served, got.served);
      compare("pending", want.pending, got.pending);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0]     cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  ecs_req_if in_ch();
  ecs_res_if out_ch();

  car_scoreboard sb;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  elevator_call_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_ch),
    .out_chan   (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("elevator_call_scheduler verification failed");
      $finish;
    end
  end

  // Drive result ready: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Observe both handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_status(out_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
    end
  end

  // Offer one request, idling first at random; return at the accepting edge
  task automatic push_request(ecs_req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic add_call(int f, int p);
    ecs_req_t r;
    r.operation = OP_ADD;
    r.floor = FLOOR_W'(f);
    r.priority_req = PRIO_W'(p);
    push_request(r);
  endtask

  task automatic tick_car(int n);
    ecs_req_t r;
    r = '0;
    r.operation = OP_TICK;
    repeat (n) push_request(r);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_setting(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.apply_setting(idx, value);
    @(posedge clk);
  endtask

  // Drop valid and wait until every status is back and the block is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random requests; floors often near the car so calls get served
  task automatic run_phase(int count, int add_pct, int idle_pct, int stall_pct, bit squeeze);
    ecs_req_t r;
    int f;
    sender_idle_pct = idle_pct;
    receiver_stall_pct <= stall_pct;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 4) hold_seq <= hold_seq + 1;
      r.operation = ($urandom_range(99) < add_pct) ? OP_ADD : OP_TICK;
      if ($urandom_range(1) == 0) begin
        f = int'(sb.position) + int'($urandom_range(16)) - 8;
        if (f < 0) f = 0;
        if (f > FLOOR_COUNT - 1) f = FLOOR_COUNT - 1;
        r.floor = FLOOR_W'(f);
      end else begin
        r.floor = FLOOR_W'($urandom_range(FLOOR_COUNT - 1));
      end
      r.priority_req = PRIO_W'($urandom_range(7));
      push_request(r);
    end
    drain();
  endtask

  initial begin
    int dir_floor[16] = '{63, 0, 1, 62, 32, 31, 21, 42, 5, 10, 15, 20, 25, 30, 35, 40};
    int dir_prio[16]  = '{7, 0, 3, 2, 5, 4, 6, 1, 2, 0, 3, 1, 7, 0, 2, 6};
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tick on an empty table, fill the table, overflow it, then travel
    tick_car(1);
    for (int i = 0; i < 16; i++) add_call(dir_floor[i], dir_prio[i]);
    add_call(63, 7);
    tick_car(6);
    run_phase(60, 30, 0, 0, 1'b0);

    // Largest step from the top floor, sender idling
    write_setting(REG_STEP_SIZE, 7);
    write_setting(REG_START_FLOOR, 63);
    run_phase(80, 35, 53, 0, 1'b0);

    // Zero step: heading changes but the car holds; receiver stalling
    write_setting(REG_STEP_SIZE, 0);
    write_setting(REG_START_FLOOR, 31);
    run_phase(60, 45, 0, 53, 1'b0);

    // Mid step, both sides idling, long output hold-off
    write_setting(REG_STEP_SIZE, 3);
    write_setting(REG_START_FLOOR, $urandom_range(FLOOR_COUNT - 1));
    run_phase(80, 50, 17, 17, 1'b1);

    write_setting(REG_STEP_SIZE, 2);
    write_setting(REG_START_FLOOR, 0);
    run_phase(80, 25, 0, 0, 1'b0);

    write_setting(REG_STEP_SIZE, 7);
    write_setting(REG_START_FLOOR, $urandom_range(FLOOR_COUNT - 1));
    run_phase(60, 40, 17, 17, 1'b0);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("elevator_call_scheduler verification clean");
    end else begin
      $display("elevator_call_scheduler verification failed");
    end
    $finish;
  end

endmodule

@@ elevator_call_scheduler.f @@
+incdir+src
src/ecs_pkg.sv
src/ecs_if.sv
src/elevator_call_scheduler.sv
test/elevator_call_scheduler_tb.sv
